@@ design/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared codes and field widths for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int REQ_W = 3;
  localparam int ST_W  = 2;
  localparam int CAP_W = 5;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_PEEK_FRONT = 3'd4;
  localparam req_t REQ_PEEK_BACK  = 3'd5;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

@@ design/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/circular_deque_unit.sv @@
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of words kept in a ring of RAM slots.
// ----------------------------------------------------------------------------
// Each input transaction is one request: push front, push back, pop front,
// pop back, peek front or peek back. Every request yields exactly one result
// transaction carrying a status (done, refused because full, refused because
// empty), the word popped, peeked or pushed (zero when refused or for an
// unknown request code), and the full and empty flags after the request.
// Words live in a single RAM of DEPTH slots with a registered read; head,
// tail and fill count live in flops. A request is accepted every cycle while
// the result path drains. Its result waits in the read stage while the RAM
// read completes, then moves to the output register, which presents it; a
// stalled result side holds it in the read stage. A
// push writes the RAM at acceptance, so a pop in the very next cycle reads
// the new word without forwarding. Writing cfg_wr_data sets the ring
// capacity (zero reads as one, values above DEPTH saturate to DEPTH) and
// empties the deque; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [cdq_pkg::CAP_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cdq_pkg::REQ_W-1:0]   in_req_type,
  input  logic [DATA_WIDTH-1:0]       in_data_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cdq_pkg::ST_W-1:0]    out_status,
  output logic [DATA_WIDTH-1:0]       out_data_out,
  output logic                        out_now_full,
  output logic                        out_now_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  // wide enough for both the config field and the count
  localparam int VW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;

  // ring state
  logic [CW-1:0] cap_r,   cap_nxt;
  logic [AW-1:0] head_r,  head_nxt;
  logic [AW-1:0] tail_r,  tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // read stage: result waiting on RAM read data
  logic                   pend_vld_r;
  cdq_pkg::status_t       pend_status_r, pend_status_nxt;
  logic                   pend_sel_r,    pend_sel_nxt;
  logic [DATA_WIDTH-1:0]  pend_word_r,   pend_word_nxt;
  logic                   pend_full_r,   pend_empty_r;

  // output register
  logic                   out_vld_r;
  cdq_pkg::status_t       out_status_r;
  logic [DATA_WIDTH-1:0]  out_data_r;
  logic                   out_full_r, out_empty_r;

  // RAM port signals
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  logic accept, pend_adv;
  logic full_now, empty_now;
  logic [AW-1:0] head_next_i, head_prev_i, tail_next_i, tail_prev_i;
  logic [VW-1:0] cfg_v;
  logic [CW-1:0] cap_eff;

  // --------------------------------------------------------------------------
  // Handshake: the read stage moves on whenever the output register is free or
  // being taken; accept a request when the read stage is empty or moves on.
  // --------------------------------------------------------------------------
  assign pend_adv = pend_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = pend_vld_r && !pend_adv;
  assign accept   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Ring index arithmetic; indices always stay below the capacity.
  // --------------------------------------------------------------------------
  always_comb begin
    head_next_i = (({1'b0, head_r} + CW'(1)) >= cap_r) ? '0 : AW'({1'b0, head_r} + CW'(1));
    tail_next_i = (({1'b0, tail_r} + CW'(1)) >= cap_r) ? '0 : AW'({1'b0, tail_r} + CW'(1));
    head_prev_i = (head_r == '0) ? AW'(cap_r - CW'(1)) : head_r - AW'(1);
    tail_prev_i = (tail_r == '0) ? AW'(cap_r - CW'(1)) : tail_r - AW'(1);
  end

  assign full_now  = (count_r >= cap_r);
  assign empty_now = (count_r == '0);

  // Saturate the capacity write into 1..DEPTH
  always_comb begin
    cfg_v = VW'(cfg_wr_data);
    if (cfg_v == '0) begin
      cap_eff = CW'(1);
    end else if (cfg_v > VW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cfg_v);
    end
  end

  // --------------------------------------------------------------------------
  // Request decode: update indices, drive the RAM, set up the read stage.
  // --------------------------------------------------------------------------
  always_comb begin
    cap_nxt         = cap_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    ram_we          = 1'b0;
    ram_waddr       = tail_r;
    ram_re          = 1'b0;
    ram_raddr       = head_r;
    pend_status_nxt = cdq_pkg::ST_DONE;
    pend_sel_nxt    = 1'b0;
    pend_word_nxt   = '0;

    if (cfg_wr_en) begin
      // new capacity, drop all held words
      cap_nxt   = cap_eff;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (accept) begin
      case (in_req_type)
        cdq_pkg::REQ_PUSH_FRONT: begin
          if (full_now) begin
            pend_status_nxt = cdq_pkg::ST_FULL;
          end else begin
            head_nxt      = head_prev_i;
            ram_we        = 1'b1;
            ram_waddr     = head_prev_i;
            count_nxt     = count_r + CW'(1);
            pend_word_nxt = in_data_in;
          end
        end
        cdq_pkg::REQ_PUSH_BACK: begin
          if (full_now) begin
            pend_status_nxt = cdq_pkg::ST_FULL;
          end else begin
            tail_nxt      = tail_next_i;
            ram_we        = 1'b1;
            ram_waddr     = tail_r;
            count_nxt     = count_r + CW'(1);
            pend_word_nxt = in_data_in;
          end
        end
        cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_PEEK_FRONT: begin
          if (empty_now) begin
            pend_status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = head_r;
            pend_sel_nxt = 1'b1;
            if (in_req_type == cdq_pkg::REQ_POP_FRONT) begin
              head_nxt  = head_next_i;
              count_nxt = count_r - CW'(1);
            end
          end
        end
        cdq_pkg::REQ_POP_BACK, cdq_pkg::REQ_PEEK_BACK: begin
          if (empty_now) begin
            pend_status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = tail_prev_i;
            pend_sel_nxt = 1'b1;
            if (in_req_type == cdq_pkg::REQ_POP_BACK) begin
              tail_nxt  = tail_prev_i;
              count_nxt = count_r - CW'(1);
            end
          end
        end
        default: begin
          // unknown request: leave state alone, report done with zero word
        end
      endcase
    end
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CW'(DEPTH < 16 ? DEPTH : 16);
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      // advance the read stage, or refill it from a new request
      if (accept) begin
        pend_vld_r <= 1'b1;
      end else if (pend_adv) begin
        pend_vld_r <= 1'b0;
      end
      // load the output register, or drop it once taken
      if (pend_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= pend_status_nxt;
      pend_sel_r    <= pend_sel_nxt;
      pend_word_r   <= pend_word_nxt;
      pend_full_r   <= (count_nxt >= cap_r);
      pend_empty_r  <= (count_nxt == '0);
    end
    if (pend_adv) begin
      out_status_r <= pend_status_r;
      out_data_r   <= pend_sel_r ? ram_rdata : pend_word_r;
      out_full_r   <= pend_full_r;
      out_empty_r  <= pend_empty_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;
  assign out_now_full  = out_full_r;
  assign out_now_empty = out_empty_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [CW-1:0] tail_sum;
  logic [AW-1:0] tail_expect;
  assign tail_sum    = {1'b0, head_r} + count_r;
  assign tail_expect = (tail_sum >= cap_r) ? AW'(tail_sum - cap_r) : AW'(tail_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("fill count exceeds capacity");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} < cap_r) && ({1'b0, tail_r} < cap_r))
    else $error("ring index outside capacity");

  a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == tail_expect)
    else $error("tail does not equal head plus count modulo capacity");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_status_r != cdq_pkg::ST_DONE) |-> (out_data_r == '0))
    else $error("refused transaction carries a nonzero word");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_full_r && out_empty_r))
    else $error("result reports full and empty together");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular deque unit.
// ----------------------------------------------------------------------------
// Requests go in through the valid/stall channel and results come back on
// the second channel. A scoreboard keeps its own copy of the ring: slots,
// head, tail, fill count and capacity. When a request is accepted, the
// scoreboard works out its result and queues it. Each accepted result is
// compared field by field with the oldest queued one. The stimulus has
// several parts. A short directed part covers refusals on empty and full,
// unknown request codes and the extreme data words. Then come back-to-back
// runs, then random bursts that lean toward filling or draining, under
// several capacity settings including the clamped ones, and last a pause
// that lets every outstanding result drain.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CAP_W      = cdq_pkg::CAP_W;
  localparam int REQ_W      = cdq_pkg::REQ_W;
  localparam int ST_W       = cdq_pkg::ST_W;

  // request codes the block must treat as no-ops
  localparam cdq_pkg::req_t REQ_UNUSED_A = 3'd6;
  localparam cdq_pkg::req_t REQ_UNUSED_B = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_e;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  typedef struct packed {
    cdq_pkg::status_t      status;
    logic [DATA_WIDTH-1:0] word;
    logic                  full;
    logic                  empty;
  } deque_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]      cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type = '0;
  logic [DATA_WIDTH-1:0] in_data_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ST_W-1:0]       out_status;
  logic [DATA_WIDTH-1:0] out_data_out;
  logic                  out_now_full;
  logic                  out_now_empty;

  idle_mode_e tx_mode = IDLE_NONE;
  idle_mode_e rx_mode = IDLE_NONE;
  int         mismatch_count = 0;

  // scoreboard copy of the ring
  logic [DATA_WIDTH-1:0] ring_slots [DEPTH];
  logic [IDX_W-1:0]      ring_head;
  logic [IDX_W-1:0]      ring_tail;
  logic [CAP_W-1:0]      ring_fill;
  logic [CAP_W-1:0]      ring_cap;

  deque_result_t pending_results [$];

  circular_deque_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_now_full  (out_now_full),
    .out_now_empty (out_now_empty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring arithmetic. Indices wrap at the current capacity, not at DEPTH.
  // --------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] ring_after(logic [IDX_W-1:0] idx);
    return (int'(idx) + 1 >= int'(ring_cap)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_before(logic [IDX_W-1:0] idx);
    logic [CAP_W-1:0] top_slot;
    top_slot = ring_cap - 1'b1;
    return (idx == '0) ? top_slot[IDX_W-1:0] : idx - 1'b1;
  endfunction

  function automatic void ring_empty();
    ring_head = '0;
    ring_tail = '0;
    ring_fill = '0;
  endfunction

  // A capacity write clamps zero to one and large values to DEPTH, and it
  // always empties the deque. Slot contents stay but cannot be reached.
  function automatic void capacity_apply(logic [CAP_W-1:0] value);
    if (value == '0) begin
      ring_cap = CAP_W'(1);
    end else if (value > DEPTH) begin
      ring_cap = CAP_W'(DEPTH);
    end else begin
      ring_cap = value;
    end
    ring_empty();
  endfunction

  // Apply one request to the scoreboard ring and return the result it owes.
  function automatic deque_result_t deque_apply(cdq_pkg::req_t req,
                                                logic [DATA_WIDTH-1:0] word);
    deque_result_t    res;
    logic             was_full;
    logic             was_empty;
    logic [IDX_W-1:0] head_w;
    logic [IDX_W-1:0] tail_w;
    was_full   = (ring_fill >= ring_cap);
    was_empty  = (ring_fill == '0);
    head_w     = IDX_W'(ring_head % ring_cap);
    tail_w     = IDX_W'(ring_tail % ring_cap);
    res.status = cdq_pkg::ST_DONE;
    res.word   = '0;
    case (req)
      cdq_pkg::REQ_PUSH_FRONT: begin
        if (was_full) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          ring_head = ring_before(head_w);
          ring_slots[ring_head] = word;
          ring_fill = ring_fill + 1'b1;
          res.word = word;
        end
      end
      cdq_pkg::REQ_PUSH_BACK: begin
        if (was_full) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          ring_slots[tail_w] = word;
          ring_tail = ring_after(tail_w);
          ring_fill = ring_fill + 1'b1;
          res.word = word;
        end
      end
      cdq_pkg::REQ_POP_FRONT: begin
        if (was_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.word = ring_slots[head_w];
          ring_head = ring_after(head_w);
          ring_fill = ring_fill - 1'b1;
        end
      end
      cdq_pkg::REQ_POP_BACK: begin
        if (was_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          ring_tail = ring_before(tail_w);
          res.word = ring_slots[ring_tail];
          ring_fill = ring_fill - 1'b1;
        end
      end
      cdq_pkg::REQ_PEEK_FRONT: begin
        if (was_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.word = ring_slots[head_w];
        end
      end
      cdq_pkg::REQ_PEEK_BACK: begin
        if (was_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.word = ring_slots[ring_before(tail_w)];
        end
      end
      default: begin
        // unknown code: leave the ring alone, report the flags as they stand
      end
    endcase
    res.full  = (ring_fill >= ring_cap);
    res.empty = (ring_fill == '0);
    return res;
  endfunction

  function automatic void check_field(string field, logic [DATA_WIDTH-1:0] want,
                                      logic [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, so the values seen
  // are the ones the block sampled at that edge. Order matters only for the
  // capacity write, and a capacity write never overlaps traffic.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (!rst_n) begin
      ring_empty();
      ring_cap = CAP_W'(DEPTH);
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        capacity_apply(cfg_wr_data);
      end
      if (in_valid && !in_stall) begin
        pending_results.insert(pending_results.size(),
                               deque_apply(in_req_type, in_data_in));
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with no request outstanding, got status %0d data %0h",
                   $time, out_status, out_data_out);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(out_status));
          check_field("data_out", want.word, out_data_out);
          check_field("now_full", DATA_WIDTH'(want.full), DATA_WIDTH'(out_now_full));
          check_field("now_empty", DATA_WIDTH'(want.empty), DATA_WIDTH'(out_now_empty));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle and stall draws. The sparse mode gives long stretches with no gaps.
  // --------------------------------------------------------------------------
  function automatic int idle_cycles(idle_mode_e mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(3, 0) == 0) ? int'($urandom_range(9, 1)) : 0;
      default:     return int'($urandom_range(9, 0));
    endcase
  endfunction

  // Result side: hold stall for a drawn number of cycles, then take one
  // transaction, then draw again.
  initial begin : result_sink
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = idle_cycles(rx_mode);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Send one request and return at the edge that accepts it. Valid stays
  // high on return. The next call lowers it only if it draws a gap, so a
  // step never sees valid both lowered and raised.
  task automatic send_request(cdq_pkg::req_t req, logic [DATA_WIDTH-1:0] word);
    int gap;
    gap = idle_cycles(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_data_in  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every queued result has been checked, then
  // let the read and output stages settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register only while nothing is in flight.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Lean the request mix toward pushes or pops so bursts reach full and empty.
  function automatic cdq_pkg::req_t pick_request(mix_e mix);
    int roll;
    int push_pct;
    int pop_pct;
    bit at_back;
    roll    = $urandom_range(99, 0);
    at_back = 1'($urandom_range(1, 0));
    if (roll < 3) begin
      return at_back ? REQ_UNUSED_B : REQ_UNUSED_A;
    end
    case (mix)
      MIX_FILL:  begin push_pct = 70; pop_pct = 20; end
      MIX_DRAIN: begin push_pct = 20; pop_pct = 70; end
      default:   begin push_pct = 45; pop_pct = 40; end
    endcase
    roll = $urandom_range(99, 0);
    if (roll < push_pct) begin
      return at_back ? cdq_pkg::REQ_PUSH_BACK : cdq_pkg::REQ_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      return at_back ? cdq_pkg::REQ_POP_BACK : cdq_pkg::REQ_POP_FRONT;
    end
    return at_back ? cdq_pkg::REQ_PEEK_BACK : cdq_pkg::REQ_PEEK_FRONT;
  endfunction

  // Random bursts of requests. Unknown codes do not count toward n_items.
  // Now and then, pause until everything is drained.
  task automatic run_traffic(int n_items);
    int            sent;
    int            burst_left;
    mix_e          mix;
    cdq_pkg::req_t req;
    sent       = 0;
    burst_left = 0;
    mix        = MIX_EVEN;
    while (sent < n_items) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        mix = mix_e'($urandom_range(2, 0));
      end
      req = pick_request(mix);
      send_request(req, pick_word());
      burst_left--;
      if (req != REQ_UNUSED_A && req != REQ_UNUSED_B) begin
        sent++;
      end
      if ($urandom_range(149, 0) == 0) begin
        drain_results();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Refusals on empty, unknown codes, extreme words, then a one-slot ring
  // reached by writing zero to the capacity register.
  task automatic test_directed_cases();
    tx_mode = IDLE_SPARSE;
    rx_mode = IDLE_SPARSE;
    // every read of an empty deque is refused
    send_request(cdq_pkg::REQ_POP_FRONT, '1);
    send_request(cdq_pkg::REQ_POP_BACK, '1);
    send_request(cdq_pkg::REQ_PEEK_FRONT, '0);
    send_request(cdq_pkg::REQ_PEEK_BACK, '0);
    send_request(REQ_UNUSED_A, '0);
    send_request(REQ_UNUSED_B, '1);
    // pushes at both ends, wrapping the head below slot zero
    send_request(cdq_pkg::REQ_PUSH_BACK, '0);
    send_request(cdq_pkg::REQ_PUSH_FRONT, '1);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'hA5A5_A5A5);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h5A5A_5A5A);
    send_request(cdq_pkg::REQ_PEEK_FRONT, '0);
    send_request(cdq_pkg::REQ_PEEK_BACK, '0);
    send_request(REQ_UNUSED_A, 32'h1234_5678);
    send_request(cdq_pkg::REQ_POP_BACK, '0);
    send_request(cdq_pkg::REQ_POP_FRONT, '0);
    send_request(cdq_pkg::REQ_POP_BACK, '0);
    send_request(cdq_pkg::REQ_POP_FRONT, '0);
    // capacity zero acts as one: one push fills it
    write_capacity(5'd0);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'h0000_0002);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0003);
    send_request(cdq_pkg::REQ_PEEK_BACK, '0);
    send_request(cdq_pkg::REQ_POP_FRONT, '0);
    send_request(cdq_pkg::REQ_POP_BACK, '0);
  endtask

  // Full rate on the request side, first with a free result side and then
  // with one that stalls heavily.
  task automatic test_back_to_back();
    write_capacity(5'd4);
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_NONE;
    run_traffic(60);
    rx_mode = IDLE_FULL;
    run_traffic(60);
  endtask

  // Random traffic under a range of capacities, including the clamped ones,
  // with the idle modes rotating so each side sees all three.
  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] caps [10];
    caps = '{5'd31, 5'd1, 5'd2, 5'd3, 5'd5, 5'd16, 5'd17, 5'd0, 5'd9, 5'd16};
    caps[8] = CAP_W'($urandom_range(31, 0));
    for (int i = 0; i < 10; i++) begin
      write_capacity(caps[i]);
      tx_mode = idle_mode_e'(i % 3);
      rx_mode = idle_mode_e'((i / 3) % 3);
      run_traffic(100);
    end
  endtask

  // Fill past full while results back up, hold until everything has come
  // back, then drain past empty.
  task automatic test_pause_until_drained();
    write_capacity(5'd16);
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_FULL;
    repeat (20) send_request(cdq_pkg::REQ_PUSH_BACK, pick_word());
    drain_results();
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_SPARSE;
    repeat (20) send_request(cdq_pkg::REQ_POP_FRONT, pick_word());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_back_to_back();
    test_capacity_sweep();
    test_pause_until_drained();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run. The limit is far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
design/cdq_pkg.sv
design/cdq_ram.sv
design/circular_deque_unit.sv
bench/testbench.sv
